[sv/ps2_mouse_packet_tracker_assert.svh]
// assertion macros used by the packet tracker checker
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PS2MT_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PS2MT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/ps2mt_pkg.sv]
// types and constants for the ps2 mouse packet tracker
package ps2mt_pkg;

    localparam int COORD_BITS_DEFAULT = 13;
    localparam int POS_X_BITS         = 13;
    localparam int POS_Y_BITS         = 12;
    localparam int CFG_DATA_BITS      = 13;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_X       = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y       = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] SCREEN_MIN = 13'd2;
    localparam logic [CFG_DATA_BITS-1:0] SCREEN_MAX = 13'd4096;
    localparam logic [POS_Y_BITS-1:0]    LIM_MAX    = 12'd4094;
    localparam logic [POS_Y_BITS-1:0]    LIM_X_RESET = 12'd1022;
    localparam logic [POS_Y_BITS-1:0]    LIM_Y_RESET = 12'd766;

    localparam int BTN_LEFT_BIT   = 0;
    localparam int BTN_RIGHT_BIT  = 1;
    localparam int BTN_MIDDLE_BIT = 2;
    localparam int SYNC_BIT       = 3;
    localparam int X_OVF_BIT      = 6;
    localparam int Y_OVF_BIT      = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       aux_flag;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_X_BITS-1:0] pos_x;
        logic [POS_Y_BITS-1:0]        pos_y;
        logic signed [7:0]            raw_dx;
        logic signed [7:0]            raw_dy;
        logic signed [7:0]            step_x;
        logic signed [7:0]            step_y;
        logic                         left_button;
        logic                         right_button;
        logic                         middle_button;
    } out_beat_t;

    typedef struct packed {
        logic                      we;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_write_t;

endpackage

[sv/ps2mt_in_stage.sv]
// input register for incoming controller beats
module ps2mt_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ps2mt_pkg::in_beat_t in_data,
    input  logic               advance,
    output logic               held_valid,
    output ps2mt_pkg::in_beat_t held_data
);

    logic                valid_reg;
    logic                valid_next;
    ps2mt_pkg::in_beat_t data_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

[sv/ps2mt_core.sv]
// packet assembly, cursor update and clipping
module ps2mt_core #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2mt_pkg::cfg_write_t cfg,
    input  logic                  step,
    input  ps2mt_pkg::in_beat_t   item,
    output logic                  res_valid,
    output ps2mt_pkg::out_beat_t  result
);

    localparam int CW = COORD_BITS;
    localparam int WW = ((COORD_BITS > ps2mt_pkg::POS_X_BITS) ?
                         COORD_BITS : ps2mt_pkg::POS_X_BITS) + 2;
    localparam int LW = ps2mt_pkg::POS_Y_BITS;

    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_XDELTA = 2'd1;
    localparam logic [1:0] PHASE_YDELTA = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [7:0]           header_reg, header_next;
    logic [7:0]           xdelta_reg, xdelta_next;
    logic signed [CW-1:0] cursor_x_reg, cursor_x_next;
    logic signed [CW-1:0] cursor_y_reg, cursor_y_next;
    logic [LW-1:0]        lim_x_reg, lim_x_next;
    logic [LW-1:0]        lim_y_reg, lim_y_next;

    logic signed [7:0]    dx, dy;
    logic signed [WW-1:0] nx_w, ny_w, nx_clip, ny_clip, lim_x_w, lim_y_w;
    logic signed [WW-1:0] start_x_w, start_y_w;
    logic signed [CW-1:0] cx_new, cy_new;
    logic signed [CW:0]   sx_d, sy_d;
    logic [LW-1:0]        lim_cfg;

    // new position with clipping
    always_comb
    begin
        dx      = signed'(xdelta_reg);
        dy      = signed'(item.data_byte);
        nx_w    = WW'(cursor_x_reg) + WW'(dx);
        ny_w    = WW'(cursor_y_reg) - WW'(dy);
        lim_x_w = WW'(signed'({1'b0, lim_x_reg}));
        lim_y_w = WW'(signed'({1'b0, lim_y_reg}));

        if (nx_w < WW'(-1))
        begin
            nx_clip = WW'(-1);
        end
        else if (nx_w > lim_x_w)
        begin
            nx_clip = lim_x_w;
        end
        else
        begin
            nx_clip = nx_w;
        end

        if (ny_w < WW'(0))
        begin
            ny_clip = WW'(0);
        end
        else if (ny_w > lim_y_w)
        begin
            ny_clip = lim_y_w;
        end
        else
        begin
            ny_clip = ny_w;
        end

        cx_new = nx_clip[CW-1:0];
        cy_new = ny_clip[CW-1:0];
        sx_d   = (CW+1)'(cx_new) - (CW+1)'(cursor_x_reg);
        sy_d   = (CW+1)'(cursor_y_reg) - (CW+1)'(cy_new);
    end

    // result fields
    always_comb
    begin
        result.pos_x  = ps2mt_pkg::POS_X_BITS'(cx_new);
        result.pos_y  = ps2mt_pkg::POS_Y_BITS'(cy_new);
        result.raw_dx = dx;
        result.raw_dy = dy;
        if (sx_d > (CW+1)'(127))
        begin
            result.step_x = 8'sh7F;
        end
        else if (sx_d < (CW+1)'(-128))
        begin
            result.step_x = 8'sh80;
        end
        else
        begin
            result.step_x = sx_d[7:0];
        end
        if (sy_d > (CW+1)'(127))
        begin
            result.step_y = 8'sh7F;
        end
        else if (sy_d < (CW+1)'(-128))
        begin
            result.step_y = 8'sh80;
        end
        else
        begin
            result.step_y = sy_d[7:0];
        end
        result.left_button   = header_reg[ps2mt_pkg::BTN_LEFT_BIT];
        result.right_button  = header_reg[ps2mt_pkg::BTN_RIGHT_BIT];
        result.middle_button = header_reg[ps2mt_pkg::BTN_MIDDLE_BIT];
    end

    // screen size saturated to its legal range, then turned into a clip limit; start positions from cfg.data
    always_comb
    begin
        if (cfg.data < ps2mt_pkg::SCREEN_MIN)
        begin
            lim_cfg = '0;
        end
        else if (cfg.data > ps2mt_pkg::SCREEN_MAX)
        begin
            lim_cfg = ps2mt_pkg::LIM_MAX;
        end
        else
        begin
            lim_cfg = LW'(cfg.data - ps2mt_pkg::SCREEN_MIN);
        end
        start_x_w = WW'(signed'(cfg.data));
        start_y_w = WW'(signed'({1'b0, cfg.data[LW-1:0]}));
    end

    // phase sequencing and state update
    always_comb
    begin
        phase_next    = phase_reg;
        header_next   = header_reg;
        xdelta_next   = xdelta_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        lim_x_next    = lim_x_reg;
        lim_y_next    = lim_y_reg;
        res_valid     = 1'b0;

        if (cfg.we)
        begin
            case (cfg.index)
                ps2mt_pkg::REG_SCREEN_WIDTH:  lim_x_next    = lim_cfg;
                ps2mt_pkg::REG_SCREEN_HEIGHT: lim_y_next    = lim_cfg;
                ps2mt_pkg::REG_START_X:       cursor_x_next = start_x_w[CW-1:0];
                ps2mt_pkg::REG_START_Y:       cursor_y_next = start_y_w[CW-1:0];
                default:                      lim_x_next    = lim_x_reg;
            endcase
        end
        else if (step && item.aux_flag)
        begin
            case (phase_reg)
                PHASE_XDELTA:
                begin
                    xdelta_next = item.data_byte;
                    phase_next  = PHASE_YDELTA;
                end
                PHASE_YDELTA:
                begin
                    phase_next = PHASE_HEADER;
                    if (!header_reg[ps2mt_pkg::X_OVF_BIT] &&
                        !header_reg[ps2mt_pkg::Y_OVF_BIT])
                    begin
                        res_valid     = 1'b1;
                        cursor_x_next = cx_new;
                        cursor_y_next = cy_new;
                    end
                end
                default:
                begin
                    header_next = item.data_byte;
                    phase_next  = item.data_byte[ps2mt_pkg::SYNC_BIT] ?
                                  PHASE_XDELTA : PHASE_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_HEADER;
            header_reg   <= '0;
            xdelta_reg   <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            lim_x_reg    <= ps2mt_pkg::LIM_X_RESET;
            lim_y_reg    <= ps2mt_pkg::LIM_Y_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            header_reg   <= header_next;
            xdelta_reg   <= xdelta_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            lim_x_reg    <= lim_x_next;
            lim_y_reg    <= lim_y_next;
        end
    end

endmodule

[sv/ps2mt_out_stage.sv]
// result register toward the receiver
module ps2mt_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 res_valid,
    input  ps2mt_pkg::out_beat_t res_data,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ps2mt_pkg::out_beat_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    ps2mt_pkg::out_beat_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res_data;
        end
    end

endmodule

[sv/ps2_mouse_packet_tracker.sv]
// ps2 mouse packet tracker: assembles mouse packets and tracks a clipped cursor
//
// in channel: one controller byte per beat with its aux flag; beats without the
//   flag pass through the input register and change nothing
// out channel: one beat per valid three-byte packet with position, raw and
//   clipped deltas and the button bits
// config port: cfg_we, cfg_index and cfg_data write screen size and start
//   position; a start write also moves the cursor at once
// path: a packet's last byte is registered in the input register at acceptance,
//   and its result is loaded into the result register when the byte advances
// throughput: one byte per cycle while the receiver keeps up; the decode and clip
//   logic between the input register and the result register is combinational
// stall: while out_valid waits on out_ready the result holds, and one more
//   byte is taken into the input register; in_ready drops only when both are
//   full and the receiver is still stalled
// reset: packet phase back to the header, cursor at 0,0, screen 1024 by 768,
//   both registers empty
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  ps2mt_pkg::in_beat_t                    in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output ps2mt_pkg::out_beat_t                   out_data,
    input  logic                                   cfg_we,
    input  logic [ps2mt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ps2mt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic                  held_valid;
    ps2mt_pkg::in_beat_t   held_data;
    logic                  can_load;
    logic                  advance;
    logic                  res_valid;
    ps2mt_pkg::out_beat_t  res_data;
    ps2mt_pkg::cfg_write_t cfg;

    assign advance   = held_valid && can_load;
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ps2mt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    ps2mt_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .item      (held_data),
        .res_valid (res_valid),
        .result    (res_data)
    );

    ps2mt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res_data  (res_data),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[sv/ps2mt_checker.sv]
// port-level checks for the ps2 mouse packet tracker, bound to the top level
`include "ps2_mouse_packet_tracker_assert.svh"

module ps2mt_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input ps2mt_pkg::in_beat_t                  in_data,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input ps2mt_pkg::out_beat_t                 out_data,
    input logic                                 cfg_we,
    input logic [ps2mt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [ps2mt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // a stalled result beat holds
    `PS2MT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // with the output free the input side never blocks
    `PS2MT_ASSERT_SAME(a_ready_when_free, clk, rst_n, !out_valid || out_ready, in_ready)

    // a fresh result comes from a mouse byte taken into the input register and then advanced
    `PS2MT_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_data.aux_flag, 2))

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (.*);

[dv/tb_ps2_mouse_packet_tracker.sv]
// self-checking testbench for the ps2 mouse packet tracker: random bytes, stalls, cursor predictor
module tb_ps2_mouse_packet_tracker;
    import ps2mt_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTED    = 10;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_X_DELTA,
        PH_Y_DELTA
    } pkt_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_beat_t  out_data;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    in_beat_t  byte_queue[$];
    out_beat_t expected_reports[$];

    pkt_phase_t         trk_phase;
    logic [7:0]         trk_header;
    logic [7:0]         trk_dx_byte;
    logic signed [12:0] trk_x;
    logic signed [12:0] trk_y;
    logic [12:0]        scr_width;
    logic [12:0]        scr_height;

    int tx_gap = 0;
    int rx_stall = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    ps2_mouse_packet_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clip_limit(logic [12:0] size);
        if (size < SCREEN_MIN)
            return int'(SCREEN_MIN) - 2;
        if (size > SCREEN_MAX)
            return int'(SCREEN_MAX) - 2;
        return int'(size) - 2;
    endfunction

    function automatic logic signed [7:0] sat8(int v);
        if (v < -128)
            return -8'sd128;
        if (v > 127)
            return 8'sd127;
        return v[7:0];
    endfunction

    function automatic void decode_byte(in_beat_t b);
        out_beat_t rpt;
        int dx;
        int dy;
        int nx;
        int ny;
        int ox;
        int oy;
        int lim;
        if (!b.aux_flag)
            return;
        case (trk_phase)
            PH_X_DELTA:
            begin
                trk_dx_byte = b.data_byte;
                trk_phase = PH_Y_DELTA;
                return;
            end
            PH_Y_DELTA:
            begin
                trk_phase = PH_HEADER;
                if (trk_header[X_OVF_BIT] || trk_header[Y_OVF_BIT])
                    return;
            end
            default:
            begin
                trk_header = b.data_byte;
                trk_phase = b.data_byte[SYNC_BIT] ? PH_X_DELTA : PH_HEADER;
                return;
            end
        endcase
        dx = int'($signed(trk_dx_byte));
        dy = int'($signed(b.data_byte));
        ox = int'(trk_x);
        oy = int'(trk_y);
        nx = ox + dx;
        ny = oy - dy;
        lim = clip_limit(scr_width);
        if (nx < -1)
            nx = -1;
        else if (nx > lim)
            nx = lim;
        lim = clip_limit(scr_height);
        if (ny < 0)
            ny = 0;
        else if (ny > lim)
            ny = lim;
        trk_x = nx[12:0];
        trk_y = ny[12:0];
        rpt.pos_x = trk_x;
        rpt.pos_y = trk_y[POS_Y_BITS-1:0];
        rpt.raw_dx = trk_dx_byte;
        rpt.raw_dy = b.data_byte;
        rpt.step_x = sat8(int'(trk_x) - ox);
        rpt.step_y = sat8(oy - int'(trk_y));
        rpt.left_button = trk_header[BTN_LEFT_BIT];
        rpt.right_button = trk_header[BTN_RIGHT_BIT];
        rpt.middle_button = trk_header[BTN_MIDDLE_BIT];
        expected_reports.push_back(rpt);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(in_data);
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    in_data <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                    tx_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        out_beat_t got;
        logic bad;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < MAX_REPORTED)
                        $display("unexpected beat: pos %0d,%0d raw %0d,%0d", got.pos_x,
                                 got.pos_y, got.raw_dx, got.raw_dy);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    bad = (got.pos_x !== want.pos_x) || (got.pos_y !== want.pos_y)
                        || (got.raw_dx !== want.raw_dx) || (got.raw_dy !== want.raw_dy)
                        || (got.step_x !== want.step_x) || (got.step_y !== want.step_y)
                        || (got.left_button !== want.left_button)
                        || (got.right_button !== want.right_button)
                        || (got.middle_button !== want.middle_button);
                    if (bad)
                    begin
                        if (mismatches < MAX_REPORTED)
                        begin
                            $display("mismatch exp: pos %0d,%0d raw %0d,%0d step %0d,%0d btn %b%b%b",
                                     want.pos_x, want.pos_y, want.raw_dx, want.raw_dy,
                                     want.step_x, want.step_y, want.middle_button,
                                     want.right_button, want.left_button);
                            $display("         got: pos %0d,%0d raw %0d,%0d step %0d,%0d btn %b%b%b",
                                     got.pos_x, got.pos_y, got.raw_dx, got.raw_dy,
                                     got.step_x, got.step_y, got.middle_button,
                                     got.right_button, got.left_button);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done <= 1'b1;
                rx_stall <= HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall <= rx_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic queue_beat(logic [7:0] data, logic aux);
        in_beat_t b;
        b.data_byte = data;
        b.aux_flag = aux;
        byte_queue.push_back(b);
    endtask

    task automatic queue_aux(logic [7:0] data);
        if ($urandom_range(0, 19) == 0)
            queue_beat(8'($urandom_range(0, 255)), 1'b0);
        queue_beat(data, 1'b1);
    endtask

    task automatic queue_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy);
        queue_aux(hdr);
        queue_aux(dx);
        queue_aux(dy);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h00;
            3: return $urandom_range(0, 1) ? 8'hFF : 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_random(int n_aux);
        int made;
        int r;
        logic [7:0] hdr;
        made = 0;
        while (made < n_aux)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                hdr = 8'($urandom_range(0, 255));
                hdr[SYNC_BIT] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                begin
                    hdr[X_OVF_BIT] = 1'b0;
                    hdr[Y_OVF_BIT] = 1'b0;
                end
                queue_packet(hdr, pick_delta(), pick_delta());
                made += 3;
            end
            else if (r < 90)
                queue_beat(8'($urandom_range(0, 255)), 1'b0);
            else
            begin
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SCREEN_WIDTH:  scr_width = val;
            REG_SCREEN_HEIGHT: scr_height = val;
            REG_START_X:       trk_x = val;
            REG_START_Y:       trk_y = {1'b0, val[POS_Y_BITS-1:0]};
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_screen(logic [12:0] w, logic [12:0] h, logic [12:0] sx, logic [12:0] sy);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
    endtask

    initial
    begin
        trk_phase = PH_HEADER;
        trk_header = '0;
        trk_dx_byte = '0;
        trk_x = '0;
        trk_y = '0;
        scr_width = 13'd1024;
        scr_height = 13'd768;

        // directed: ignored byte, header without sync, overflow discards, extremes
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h07, 1'b1);
        queue_packet(8'h0F, 8'h7F, 8'h80);
        queue_packet(8'h48, 8'h01, 8'h01);
        queue_packet(8'h88, 8'h01, 8'h01);
        queue_packet(8'h08, 8'h80, 8'h7F);
        queue_beat(8'h09, 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b1);
        queue_packet(8'hC8, 8'hFF, 8'hFF);
        queue_packet(8'h0C, 8'hFF, 8'h01);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        set_screen(13'd2, 13'd2, 13'h1FFF, 13'd0);
        queue_random(80);
        wait_idle();

        set_screen(13'd4096, 13'd4096, 13'd4094, 13'd4094);
        queue_random(120);
        hold_off_req = 1'b1;
        wait_idle();

        set_screen(13'd0, 13'h1FFF, 13'($urandom_range(0, 8191)),
                   13'($urandom_range(0, 8191)));
        queue_random(100);
        wait_idle();

        no_idle = 1'b1;
        set_screen(13'($urandom_range(2, 200)), 13'($urandom_range(2, 200)),
                   13'($urandom_range(0, 8191)), 13'($urandom_range(0, 4095)));
        queue_random(100);
        wait_idle();
        no_idle = 1'b0;

        set_screen(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                   13'($urandom_range(0, 4095)), 13'($urandom_range(0, 4095)));
        queue_random(100);
        wait_idle();

        set_screen(13'd640, 13'd480, 13'd4095, 13'd4095);
        queue_random(100);
        wait_idle();

        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ps2mt_pkg.sv
sv/ps2mt_in_stage.sv
sv/ps2mt_core.sv
sv/ps2mt_out_stage.sv
sv/ps2_mouse_packet_tracker.sv
sv/ps2mt_checker.sv
dv/tb_ps2_mouse_packet_tracker.sv
